>>> rtl/audio_level_event_detector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the audio level event detector
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while the asynchronous reset is active.
// ----------------------------------------------------------------------------
`ifndef AUDIO_LEVEL_EVENT_DETECTOR_ASSERT_SVH
`define AUDIO_LEVEL_EVENT_DETECTOR_ASSERT_SVH

// Condition implies consequence in the same cycle
`define ALED_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("same-cycle check failed");

// Condition implies consequence in the next cycle
`define ALED_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/aled_pkg.sv
// ----------------------------------------------------------------------------
// Audio level event detector package
// Class and event codes, register indexes, reset values and the per-class
// sustain and hold times in milliseconds.
// ----------------------------------------------------------------------------
`default_nettype none

package aled_pkg;

    localparam int LevelW = 8;
    localparam int TimeW  = 32;
    localparam int HoldW  = 12;
    localparam int CfgIdxW = 2;

    typedef enum logic [1:0] {
        CLS_STANDARD = 2'd0,
        CLS_QUIET    = 2'd1,
        CLS_LOUD     = 2'd2
    } level_class_t;

    typedef enum logic [1:0] {
        EVT_NONE      = 2'd0,
        EVT_DECREASED = 2'd1,
        EVT_INCREASED = 2'd2,
        EVT_RETURN    = 2'd3
    } level_event_t;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_QUIET_FLOOR = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_QUIET_PEAK  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_LOUD_FLOOR  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_LOUD_PEAK   = 2'd3;

    // Register reset values
    localparam logic [LevelW-1:0] QUIET_FLOOR_RST = 8'd18;
    localparam logic [LevelW-1:0] QUIET_PEAK_RST  = 8'd75;
    localparam logic [LevelW-1:0] LOUD_FLOOR_RST  = 8'd60;
    localparam logic [LevelW-1:0] LOUD_PEAK_RST   = 8'd95;

    // Sustain times per class
    localparam logic [TimeW-1:0] SUSTAIN_QUIET_MS    = 32'd600;
    localparam logic [TimeW-1:0] SUSTAIN_LOUD_MS     = 32'd200;
    localparam logic [TimeW-1:0] SUSTAIN_STANDARD_MS = 32'd1000;

    // Hold times loaded on confirmation
    localparam logic [HoldW-1:0] HOLD_QUIET_MS    = 12'd200;
    localparam logic [HoldW-1:0] HOLD_LOUD_MS     = 12'd800;
    localparam logic [HoldW-1:0] HOLD_STANDARD_MS = 12'd4000;

endpackage

`default_nettype wire

>>> rtl/audio_level_event_detector.sv
// ----------------------------------------------------------------------------
// Audio level event detector
// Classes each frame summary quiet, loud or standard, tracks a pending class
// with a sustain timer, confirms it once its sustain time and the last hold
// time have passed, and reports the confirmed class and the transition event.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    floor_level, peak_level, time_ms
//   out       output     out_valid / out_ready  level_class, level_event,
//                                               pending_class
//   cfg       input      cfg_write_en           cfg_index, cfg_data
//
// One frame per cycle sustained while the output is not stalled. The input
// register feeds the classify and confirm logic, which loads the result
// register and the timer state together.
// Reset clears the pipeline valids and loads the register and state defaults.
// A stalled result holds the result register; the input register still takes
// a frame while it is empty, then the input side stalls as well.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_level_event_detector (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [aled_pkg::LevelW-1:0]     floor_level,
    input  wire logic [aled_pkg::LevelW-1:0]     peak_level,
    input  wire logic [aled_pkg::TimeW-1:0]      time_ms,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0]                           level_class,
    output logic [1:0]                           level_event,
    output logic [1:0]                           pending_class,
    input  wire logic                            cfg_write_en,
    input  wire logic [aled_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [aled_pkg::LevelW-1:0]     cfg_data
);

`include "audio_level_event_detector_assert.svh"

    // Configuration registers
    logic [aled_pkg::LevelW-1:0] quiet_floor_reg;
    logic [aled_pkg::LevelW-1:0] quiet_peak_reg;
    logic [aled_pkg::LevelW-1:0] loud_floor_reg;
    logic [aled_pkg::LevelW-1:0] loud_peak_reg;

    // Input register
    logic                        in_valid_reg;
    logic [aled_pkg::LevelW-1:0] floor_reg;
    logic [aled_pkg::LevelW-1:0] peak_reg;
    logic [aled_pkg::TimeW-1:0]  time_reg;

    // Detector state
    aled_pkg::level_class_t      confirmed_reg, confirmed_next;
    aled_pkg::level_class_t      candidate_reg;
    logic [aled_pkg::TimeW-1:0]  since_reg, since_next;
    logic [aled_pkg::TimeW-1:0]  confirmed_at_reg;
    logic [aled_pkg::HoldW-1:0]  hold_reg;

    // Result register
    logic                        out_valid_reg;
    aled_pkg::level_class_t      out_class_reg;
    aled_pkg::level_event_t      out_event_reg, event_next;
    aled_pkg::level_class_t      out_pending_reg;

    // Combinational work
    aled_pkg::level_class_t      cls;
    logic [aled_pkg::TimeW-1:0]  sustain;
    logic [aled_pkg::HoldW-1:0]  new_hold;
    logic [aled_pkg::TimeW-1:0]  diff_since, diff_conf;
    logic [aled_pkg::TimeW-1:0]  mag_since, mag_conf;
    logic                        confirm;
    logic                        work;

    // Handshake: advance the input register whenever the result can load
    assign work      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || work;

    // Classify the frame; quiet wins over loud
    always_comb
    begin
        if (floor_reg <= quiet_floor_reg && peak_reg <= quiet_peak_reg)
        begin
            cls      = aled_pkg::CLS_QUIET;
            sustain  = aled_pkg::SUSTAIN_QUIET_MS;
            new_hold = aled_pkg::HOLD_QUIET_MS;
        end
        else if (floor_reg >= loud_floor_reg && peak_reg >= loud_peak_reg)
        begin
            cls      = aled_pkg::CLS_LOUD;
            sustain  = aled_pkg::SUSTAIN_LOUD_MS;
            new_hold = aled_pkg::HOLD_LOUD_MS;
        end
        else
        begin
            cls      = aled_pkg::CLS_STANDARD;
            sustain  = aled_pkg::SUSTAIN_STANDARD_MS;
            new_hold = aled_pkg::HOLD_STANDARD_MS;
        end
    end

    // Restart the sustain timer on a class change, then take elapsed magnitudes
    always_comb
    begin
        since_next = (cls != candidate_reg) ? time_reg : since_reg;
        diff_since = time_reg - since_next;
        diff_conf  = time_reg - confirmed_at_reg;
        mag_since  = diff_since[aled_pkg::TimeW-1] ? (~diff_since + 1'b1) : diff_since;
        mag_conf   = diff_conf[aled_pkg::TimeW-1]  ? (~diff_conf + 1'b1)  : diff_conf;
        confirm    = (mag_since > sustain) &&
                     (mag_conf > {{(aled_pkg::TimeW-aled_pkg::HoldW){1'b0}}, hold_reg});
        confirmed_next = confirm ? cls : confirmed_reg;
    end

    // Derive the transition event from old and new confirmed class
    always_comb
    begin
        if (confirmed_next == confirmed_reg)
            event_next = aled_pkg::EVT_NONE;
        else if (confirmed_reg == aled_pkg::CLS_STANDARD)
            event_next = (confirmed_next == aled_pkg::CLS_QUIET) ?
                         aled_pkg::EVT_DECREASED : aled_pkg::EVT_INCREASED;
        else
            event_next = aled_pkg::EVT_RETURN;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_floor_reg <= aled_pkg::QUIET_FLOOR_RST;
            quiet_peak_reg  <= aled_pkg::QUIET_PEAK_RST;
            loud_floor_reg  <= aled_pkg::LOUD_FLOOR_RST;
            loud_peak_reg   <= aled_pkg::LOUD_PEAK_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                aled_pkg::REG_QUIET_FLOOR: quiet_floor_reg <= cfg_data;
                aled_pkg::REG_QUIET_PEAK:  quiet_peak_reg  <= cfg_data;
                aled_pkg::REG_LOUD_FLOOR:  loud_floor_reg  <= cfg_data;
                aled_pkg::REG_LOUD_PEAK:   loud_peak_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            floor_reg <= floor_level;
            peak_reg  <= peak_level;
            time_reg  <= time_ms;
        end
    end

    // Update detector state as each frame is worked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirmed_reg    <= aled_pkg::CLS_STANDARD;
            candidate_reg    <= aled_pkg::CLS_STANDARD;
            since_reg        <= '0;
            confirmed_at_reg <= '0;
            hold_reg         <= aled_pkg::HOLD_STANDARD_MS;
        end
        else if (work)
        begin
            candidate_reg <= cls;
            confirmed_reg <= confirmed_next;
            if (confirm)
            begin
                since_reg        <= time_reg;
                confirmed_at_reg <= time_reg;
                hold_reg         <= new_hold;
            end
            else
                since_reg <= since_next;
        end
    end

    // Load the result register; hold it while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || out_ready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (work)
        begin
            out_class_reg   <= confirmed_next;
            out_event_reg   <= event_next;
            out_pending_reg <= cls;
        end
    end

    assign out_valid     = out_valid_reg;
    assign level_class   = out_class_reg;
    assign level_event   = out_event_reg;
    assign pending_class = out_pending_reg;

    // A class change is always a confirmation of the pending class
    `ALED_ASSERT_SAME(a_event_matches_pending, clk, rst_n,
        out_valid_reg && out_event_reg != aled_pkg::EVT_NONE,
        out_class_reg == out_pending_reg)

    // Decrease lands in quiet, increase lands in loud
    `ALED_ASSERT_SAME(a_event_direction, clk, rst_n,
        out_valid_reg && (out_event_reg == aled_pkg::EVT_DECREASED ||
                          out_event_reg == aled_pkg::EVT_INCREASED),
        (out_event_reg == aled_pkg::EVT_DECREASED && out_class_reg == aled_pkg::CLS_QUIET) ||
        (out_event_reg == aled_pkg::EVT_INCREASED && out_class_reg == aled_pkg::CLS_LOUD))

    // Input stalls only with both stages full and the output held
    `ALED_ASSERT_SAME(a_stall_cause, clk, rst_n,
        !in_ready,
        in_valid_reg && out_valid_reg && !out_ready)

    // Hold time is always one of the class values
    `ALED_ASSERT_SAME(a_hold_legal, clk, rst_n,
        1'b1,
        hold_reg == aled_pkg::HOLD_QUIET_MS || hold_reg == aled_pkg::HOLD_LOUD_MS ||
        hold_reg == aled_pkg::HOLD_STANDARD_MS)

    // A worked frame always yields a result next cycle
    `ALED_ASSERT_NEXT(a_work_gives_result, clk, rst_n,
        work,
        out_valid_reg)

endmodule

`default_nettype wire
